/* rtl/lfsr_bit_statistics_assert.svh */
// assertion macros for the lfsr bit statistics block
// both forms sample on clk and are disabled while rst is high
`ifndef LFSR_BIT_STATISTICS_ASSERT_SVH
`define LFSR_BIT_STATISTICS_ASSERT_SVH

`ifndef ASSERT_OFF
`define LBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LBS_ASSERT(lbl, prop, msg)
`define LBS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/lbs_pkg.sv */
package lbs_pkg;

  localparam int SEED_W = 4;
  localparam logic [SEED_W-1:0] SEED_RESET = 4'h9;

  localparam int MAX_LAG = 64;
  localparam int LAG_IW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;

  localparam int COUNT_W = 32;
  localparam int OUT_W = 32;

  localparam int BITS_W = 7;
  localparam logic [BITS_W-1:0] HISTORY_LIMIT = 7'd64;
  localparam logic [BITS_W-1:0] PERIOD_LIMIT = 7'd15;

  localparam int PAT_MAX_LEN = 4;
  localparam int PAT_SLOTS = 30;

  // register index decoded from paddr[2]
  localparam logic REG_SEED = 1'b0;

  typedef logic [COUNT_W-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_STEP     = 2'd0,
    OP_READ_PAT = 2'd1,
    OP_READ_LAG = 2'd2,
    OP_RESTART  = 2'd3
  } op_t;

  // broadcast to every cell and the pattern bank
  typedef struct packed {
    logic clear;
    logic step;
    logic count;
    logic newest;
  } step_ctl_t;

  function automatic count_t sat_inc(count_t c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

/* rtl/lbs_if.sv */
interface lbs_req_if;
  import lbs_pkg::*;

  logic       valid;
  logic       ready;
  op_t        op;
  logic [2:0] pattern_length;
  logic [3:0] pattern_value;
  logic [5:0] lag;
  logic       disagree;

  modport source (
    output valid, op, pattern_length, pattern_value, lag, disagree,
    input  ready
  );
  modport sink (
    input  valid, op, pattern_length, pattern_value, lag, disagree,
    output ready
  );
endinterface

interface lbs_rsp_if;
  logic        valid;
  logic        ready;
  logic        generated_bit;
  logic [31:0] count_value;
  logic [3:0]  period_length;

  modport source (
    output valid, generated_bit, count_value, period_length,
    input  ready
  );
  modport sink (
    input  valid, generated_bit, count_value, period_length,
    output ready
  );
endinterface

/* rtl/lfsr_bit_statistics.sv */
// lfsr_bit_statistics: 4-bit x^4+x+1 generator with online bit statistics
// the result word is registered at the edge that takes the request
// throughput: 1 request word per cycle unless the result word stalls; every lag cell and
//   pattern counter updates in parallel in that cycle, so the one-step generator feedback sets the pace
// reset: synchronous on rst, seed = 9, shift register loaded with 9, all counters,
//   history and period cleared in the same cycle, no clearing pass
`include "lfsr_bit_statistics_assert.svh"

module lfsr_bit_statistics (
  input  logic        clk,
  input  logic        rst,
  lbs_req_if.sink     req,
  lbs_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lbs_pkg::*;

  // configuration register
  logic [SEED_W-1:0] seed;

  // generator state
  logic [SEED_W-1:0] shift_bits;
  logic [SEED_W-1:0] start_bits;
  logic [BITS_W-1:0] bits_seen;
  logic [3:0]        found_period;

  // output register
  logic        out_valid;
  logic        out_bit;
  logic [31:0] out_count;
  logic [3:0]  out_period;

  logic              req_fire;
  logic              fb;
  logic [SEED_W-1:0] shift_next;
  logic [BITS_W-1:0] bits_seen_next;
  logic [3:0]        found_next;
  logic              period_hit;
  step_ctl_t         ctl;

  logic              res_bit;
  logic [31:0]       res_count;
  logic [3:0]        res_period;

  count_t            pat_count;
  logic              lag_ok;
  logic [LAG_IW-1:0] lag_idx;

  // chain of lag cells
  logic   hist_chain [MAX_LAG+1];
  count_t agree_cnt  [MAX_LAG];
  count_t dis_cnt    [MAX_LAG];

  // ---------------------------------------------------------------
  // apb config, seed lives at byte address 0
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEED) ? 32'(seed) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_SEED) begin
      seed <= pwdata[SEED_W-1:0];
    end
  end

  // ---------------------------------------------------------------
  // handshake: output register frees as soon as the word is taken
  // ---------------------------------------------------------------
  assign req.ready = !out_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  // ---------------------------------------------------------------
  // generator step
  // ---------------------------------------------------------------
  // feedback bit 0 xor bit 1 enters at the top, also the produced bit
  assign fb         = shift_bits[0] ^ shift_bits[1];
  assign shift_next = {fb, shift_bits[SEED_W-1:1]};

  // bits seen saturates at the history length
  assign bits_seen_next = (bits_seen < HISTORY_LIMIT) ? bits_seen + 7'd1 : bits_seen;

  // first return to the loaded value within 15 steps
  assign period_hit = (found_period == '0) && (bits_seen_next <= PERIOD_LIMIT) &&
                      (shift_next == start_bits);
  assign found_next = period_hit ? bits_seen_next[3:0] : found_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits   <= SEED_RESET;
      start_bits   <= SEED_RESET;
      bits_seen    <= '0;
      found_period <= '0;
    end else if (req_fire) begin
      unique case (req.op)
        OP_STEP: begin
          shift_bits   <= shift_next;
          bits_seen    <= bits_seen_next;
          found_period <= found_next;
        end
        OP_RESTART: begin
          shift_bits   <= seed;
          start_bits   <= seed;
          bits_seen    <= '0;
          found_period <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // control broadcast to the cells and the pattern bank
  assign ctl.clear  = rst || (req_fire && req.op == OP_RESTART);
  assign ctl.step   = req_fire && req.op == OP_STEP;
  assign ctl.count  = bits_seen_next >= BITS_W'(MAX_LAG);
  assign ctl.newest = fb;

  // ---------------------------------------------------------------
  // lag cells: cell j holds history bit j, the newest bit feeds cell 0
  // ---------------------------------------------------------------
  assign hist_chain[0] = fb;

  for (genvar j = 0; j < MAX_LAG; j++) begin : g_lag
    lbs_lag_cell u_cell (
      .clk          (clk),
      .ctl          (ctl),
      .hist_in      (hist_chain[j]),
      .hist_out     (hist_chain[j+1]),
      .agree_cnt    (agree_cnt[j]),
      .disagree_cnt (dis_cnt[j])
    );
  end

  // ---------------------------------------------------------------
  // pattern counters for lengths 1 to 4
  // ---------------------------------------------------------------
  lbs_pattern_bank u_pat (
    .clk            (clk),
    .ctl            (ctl),
    .bits_seen_next (bits_seen_next),
    .rd_len         (req.pattern_length),
    .rd_val         (req.pattern_value),
    .rd_count       (pat_count)
  );

  // ---------------------------------------------------------------
  // result word
  // ---------------------------------------------------------------
  assign lag_ok  = {1'b0, req.lag} < 7'(MAX_LAG);
  assign lag_idx = req.lag[LAG_IW-1:0];

  always_comb begin
    res_bit    = 1'b0;
    res_count  = '0;
    res_period = found_period;
    unique case (req.op)
      OP_STEP: begin
        res_bit    = fb;
        res_period = found_next;
      end
      OP_READ_PAT: begin
        res_count = OUT_W'(pat_count);
      end
      OP_READ_LAG: begin
        if (lag_ok) begin
          res_count = req.disagree ? OUT_W'(dis_cnt[lag_idx]) : OUT_W'(agree_cnt[lag_idx]);
        end
      end
      OP_RESTART: begin
        res_period = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      out_bit    <= res_bit;
      out_count  <= res_count;
      out_period <= res_period;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.generated_bit = out_bit;
  assign rsp.count_value   = out_count;
  assign rsp.period_length = out_period;

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  // a found period only goes away on restart
  `LBS_ASSERT_NEXT(a_period_sticky, found_period != '0 && !(req_fire && req.op == OP_RESTART), found_period == $past(found_period), "found period changed without restart")
  // each step below the limit adds exactly one seen bit
  `LBS_ASSERT_NEXT(a_bits_seen_step, req_fire && req.op == OP_STEP && bits_seen < HISTORY_LIMIT, bits_seen == $past(bits_seen) + 7'd1, "bits seen did not advance on step")
  // lag zero always agrees with itself
  `LBS_ASSERT(a_lag0_agree, dis_cnt[0] == '0, "lag zero disagreement counted")
  // a held result word blocks new requests
  `LBS_ASSERT(a_stall_blocks, out_valid && !rsp.ready |-> !req.ready, "request taken while result word stalled")

endmodule

/* rtl/lbs_lag_cell.sv */
module lbs_lag_cell (
  input  logic               clk,
  input  lbs_pkg::step_ctl_t ctl,
  input  logic               hist_in,
  output logic               hist_out,
  output lbs_pkg::count_t    agree_cnt,
  output lbs_pkg::count_t    disagree_cnt
);
  import lbs_pkg::*;

  logic   hist;
  count_t agree;
  count_t disag;

  // hist holds the history bit at this cell's lag
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      hist  <= 1'b0;
      agree <= '0;
      disag <= '0;
    end else if (ctl.step) begin
      hist <= hist_in;
      if (ctl.count) begin
        if (hist_in == ctl.newest) begin
          agree <= sat_inc(agree);
        end else begin
          disag <= sat_inc(disag);
        end
      end
    end
  end

  assign hist_out     = hist;
  assign agree_cnt    = agree;
  assign disagree_cnt = disag;

endmodule

/* rtl/lbs_pattern_bank.sv */
module lbs_pattern_bank (
  input  logic                        clk,
  input  lbs_pkg::step_ctl_t          ctl,
  input  logic [lbs_pkg::BITS_W-1:0]  bits_seen_next,
  input  logic [2:0]                  rd_len,
  input  logic [3:0]                  rd_val,
  output lbs_pkg::count_t             rd_count
);
  import lbs_pkg::*;

  logic [PAT_MAX_LEN-2:0] win;
  logic [PAT_MAX_LEN-1:0] win_new;
  count_t                 cnt [PAT_SLOTS];

  assign win_new = {win, ctl.newest};

  // slot of length l, pattern v sits at 2^l - 2 + v
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      win <= '0;
      for (int k = 0; k < PAT_SLOTS; k++) begin
        cnt[k] <= '0;
      end
    end else if (ctl.step) begin
      win <= win_new[PAT_MAX_LEN-2:0];
      for (int l = 1; l <= PAT_MAX_LEN; l++) begin
        for (int v = 0; v < (1 << l); v++) begin
          if (bits_seen_next >= BITS_W'(l) &&
              (win_new & 4'((1 << l) - 1)) == 4'(v)) begin
            cnt[(1 << l) - 2 + v] <= sat_inc(cnt[(1 << l) - 2 + v]);
          end
        end
      end
    end
  end

  always_comb begin
    rd_count = '0;
    for (int l = 1; l <= PAT_MAX_LEN; l++) begin
      for (int v = 0; v < (1 << l); v++) begin
        if (rd_len == 3'(l) && (rd_val & 4'((1 << l) - 1)) == 4'(v)) begin
          rd_count = cnt[(1 << l) - 2 + v];
        end
      end
    end
  end

endmodule
